[design/sccr_pkg.sv]
// ----------------------------------------------------------------------------
// sccr_pkg
// Shared types and constants for the sector cache clock replacement core.
// ----------------------------------------------------------------------------
package sccr_pkg;

  localparam int unsigned CacheEntries = 64;
  localparam int unsigned IdxW         = $clog2(CacheEntries);
  localparam int unsigned CntW         = $clog2(CacheEntries + 1);
  localparam int unsigned TagW         = 32;
  localparam int unsigned SlotW        = 6;
  localparam int unsigned OpW          = 2;
  localparam int unsigned TotalW       = 32;
  localparam int unsigned OutDataW     = 112;

  typedef enum logic [OpW-1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FLUSH = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HIT,
    ST_SWEEP,
    ST_VICTIM,
    ST_FLUSH,
    ST_FLUSH_OUT,
    ST_CLEAR
  } state_e;

  // Tag RAM access: one write and one read address per cycle.
  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    logic [TagW-1:0] wdata;
    logic [IdxW-1:0] raddr;
  } ram_req_t;

endpackage

[design/sccr_tag_ram.sv]
// ----------------------------------------------------------------------------
// sccr_tag_ram
// Single-write, single-read tag store with a registered read port.
// ----------------------------------------------------------------------------
module sccr_tag_ram (
  input  logic                           clk_i,
  input  sccr_pkg::ram_req_t             req_i,
  output logic [sccr_pkg::TagW-1:0]      rdata_o
);

  logic [sccr_pkg::TagW-1:0] mem [sccr_pkg::CacheEntries];
  logic [sccr_pkg::TagW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

[design/sector_cache_clock_replacement_core.sv]
// ----------------------------------------------------------------------------
// sector_cache_clock_replacement_core
// Tag and clock (second-chance) replacement engine of a fully associative
// sector cache, with hit/miss counters and a dirty-entry flush.
// ----------------------------------------------------------------------------
// Sequence: a hit scans the tags up to the matching entry and then writes the
//   result register; a miss scans every tag, sweeps the hand to a victim and
//   reads the victim's tag before writing its result.
// Throughput: one transaction at a time, passing through idle between them;
//   the tag RAM read port, scanned one entry per cycle, sets the rate. A flush
//   emits one result per dirty entry. A new transaction is taken while the
//   last result waits.
// Reset: control, counters, hand and valid/dirty/referenced bits clear at
//   once; the tag RAM is not cleared since a tag is only read when valid.
// ----------------------------------------------------------------------------
module sector_cache_clock_replacement_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Slave side
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [31:0]                        s_axis_tdata_i,  // [31:0] sector
  input  logic [1:0]                         s_axis_tuser_i,  // [1:0] operation
  // Master side
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [0] hit, [6:1] slot, [7] writeback_needed, [39:8] writeback_sector,
  // [40] fill_needed, [72:41] hit_total, [104:73] miss_total, [111:105] zero
  output logic [sccr_pkg::OutDataW-1:0]      m_axis_tdata_o,
  output logic                               m_axis_tlast_o   // last
);

  localparam int unsigned N    = sccr_pkg::CacheEntries;
  localparam int unsigned IdxW = sccr_pkg::IdxW;
  localparam int unsigned CntW = sccr_pkg::CntW;

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  sccr_pkg::state_e            state_q, state_d;
  sccr_pkg::op_e               op_q, op_d;
  logic [sccr_pkg::TagW-1:0]   sector_q, sector_d;
  logic [CntW-1:0]             idx_q, idx_d;        // scan / flush pointer
  logic                        cmp_vld_q, cmp_vld_d; // a tag read is in flight
  logic [IdxW-1:0]             cmp_idx_q, cmp_idx_d;
  logic [IdxW-1:0]             slot_q, slot_d;      // hit slot
  logic [IdxW-1:0]             hand_q, hand_d;
  logic [N-1:0]                valid_q, valid_d;
  logic [N-1:0]                dirty_q, dirty_d;
  logic [N-1:0]                ref_q, ref_d;
  logic [sccr_pkg::TotalW-1:0] hit_cnt_q, hit_cnt_d;
  logic [sccr_pkg::TotalW-1:0] miss_cnt_q, miss_cnt_d;

  // Output register
  logic                          out_valid_q, out_valid_d;
  logic [sccr_pkg::OutDataW-1:0] out_data_q, out_data_d;
  logic                          out_last_q, out_last_d;

  // Tag RAM
  sccr_pkg::ram_req_t        ram_req;
  logic [sccr_pkg::TagW-1:0] ram_rdata;

  sccr_tag_ram u_tag_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Shared decode
  // --------------------------------------------------------------------------
  logic          in_fire;
  logic          out_free;
  logic          scan_match;
  logic          scan_done;
  logic          hand_stop;
  logic [N-1:0]  vd;
  logic [N-1:0]  above_mask;
  logic          flush_last;
  logic [IdxW-1:0] idx_lo;
  logic [IdxW-1:0] hand_next;
  logic [sccr_pkg::TotalW-1:0] hit_inc, miss_inc;

  assign s_axis_tready_o = (state_q == sccr_pkg::ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  // Result register can take a new result this cycle.
  assign out_free        = !out_valid_q || m_axis_tready_i;

  assign idx_lo     = idx_q[IdxW-1:0];
  // Tag read data belongs to cmp_idx_q in the cycle after issue.
  assign scan_match = cmp_vld_q && valid_q[cmp_idx_q] && (ram_rdata == sector_q);
  assign scan_done  = cmp_vld_q && (cmp_idx_q == IdxW'(N - 1));
  // Sweep stops on an invalid or unreferenced entry.
  assign hand_stop  = !valid_q[hand_q] || !ref_q[hand_q];
  assign hand_next  = (hand_q == IdxW'(N - 1)) ? '0 : hand_q + 1'b1;

  assign vd = valid_q & dirty_q;

  always_comb begin
    for (int k = 0; k < N; k++) begin
      above_mask[k] = (CntW'(k) > idx_q);
    end
  end

  // No dirty entry left beyond the one being flushed.
  assign flush_last = ~|(vd & above_mask);

  // Saturating counters
  assign hit_inc  = (hit_cnt_q == '1) ? hit_cnt_q : hit_cnt_q + 1'b1;
  assign miss_inc = (miss_cnt_q == '1) ? miss_cnt_q : miss_cnt_q + 1'b1;

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sccr_pkg::ST_IDLE: begin
        if (in_fire) begin
          unique case (sccr_pkg::op_e'(s_axis_tuser_i))
            sccr_pkg::OP_READ,
            sccr_pkg::OP_WRITE: state_d = sccr_pkg::ST_SCAN;
            sccr_pkg::OP_FLUSH: state_d = sccr_pkg::ST_FLUSH;
            sccr_pkg::OP_CLEAR: state_d = sccr_pkg::ST_CLEAR;
            default:            state_d = sccr_pkg::ST_IDLE;
          endcase
        end
      end
      sccr_pkg::ST_SCAN: begin
        priority if (scan_match) begin
          state_d = sccr_pkg::ST_HIT;
        end else if (scan_done) begin
          state_d = sccr_pkg::ST_SWEEP;
        end
      end
      sccr_pkg::ST_HIT: begin
        if (out_free) state_d = sccr_pkg::ST_IDLE;
      end
      sccr_pkg::ST_SWEEP: begin
        if (hand_stop) state_d = sccr_pkg::ST_VICTIM;
      end
      sccr_pkg::ST_VICTIM: begin
        if (out_free) state_d = sccr_pkg::ST_IDLE;
      end
      sccr_pkg::ST_FLUSH: begin
        priority if (idx_q == CntW'(N)) begin
          state_d = sccr_pkg::ST_IDLE;
        end else if (vd[idx_lo]) begin
          state_d = sccr_pkg::ST_FLUSH_OUT;
        end
      end
      sccr_pkg::ST_FLUSH_OUT: begin
        if (out_free) begin
          state_d = flush_last ? sccr_pkg::ST_IDLE : sccr_pkg::ST_FLUSH;
        end
      end
      sccr_pkg::ST_CLEAR: begin
        if (out_free) state_d = sccr_pkg::ST_IDLE;
      end
      default: state_d = sccr_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath and outputs
  // --------------------------------------------------------------------------
  always_comb begin
    op_d        = op_q;
    sector_d    = sector_q;
    idx_d       = idx_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    slot_d      = slot_q;
    hand_d      = hand_q;
    valid_d     = valid_q;
    dirty_d     = dirty_q;
    ref_d       = ref_q;
    hit_cnt_d   = hit_cnt_q;
    miss_cnt_d  = miss_cnt_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;

    ram_req.we    = 1'b0;
    ram_req.waddr = hand_q;
    ram_req.wdata = sector_q;
    ram_req.raddr = hand_q;

    unique case (state_q)
      sccr_pkg::ST_IDLE: begin
        if (in_fire) begin
          op_d     = sccr_pkg::op_e'(s_axis_tuser_i);
          sector_d = s_axis_tdata_i;
          idx_d    = '0;
        end
      end

      sccr_pkg::ST_SCAN: begin
        // Issue one tag read per cycle; compare the one issued last cycle.
        ram_req.raddr = idx_lo;
        if (idx_q != CntW'(N)) begin
          cmp_vld_d = 1'b1;
          cmp_idx_d = idx_lo;
          idx_d     = idx_q + 1'b1;
        end
        if (scan_match) begin
          slot_d    = cmp_idx_q;
          cmp_vld_d = 1'b0;
        end else if (scan_done) begin
          cmp_vld_d = 1'b0;
        end
      end

      sccr_pkg::ST_HIT: begin
        if (out_free) begin
          hit_cnt_d      = hit_inc;
          ref_d[slot_q]  = 1'b1;
          if (op_q == sccr_pkg::OP_WRITE) dirty_d[slot_q] = 1'b1;
          out_valid_d    = 1'b1;
          out_last_d     = 1'b1;
          out_data_d     = {7'd0, miss_cnt_q, hit_inc, 1'b0, 32'd0, 1'b0,
                            sccr_pkg::SlotW'(slot_q), 1'b1};
        end
      end

      sccr_pkg::ST_SWEEP: begin
        // Give each referenced entry a second chance; hold on the victim.
        if (!hand_stop) begin
          ref_d[hand_q] = 1'b0;
          hand_d        = hand_next;
        end
      end

      sccr_pkg::ST_VICTIM: begin
        // Tag of the victim is on the read port now.
        if (out_free) begin
          miss_cnt_d     = miss_inc;
          ram_req.we     = 1'b1;
          valid_d[hand_q] = 1'b1;
          dirty_d[hand_q] = (op_q == sccr_pkg::OP_WRITE);
          ref_d[hand_q]   = 1'b1;
          out_valid_d    = 1'b1;
          out_last_d     = 1'b1;
          out_data_d     = {7'd0, miss_inc, hit_cnt_q, 1'b1,
                            vd[hand_q] ? ram_rdata : 32'd0, vd[hand_q],
                            sccr_pkg::SlotW'(hand_q), 1'b0};
        end
      end

      sccr_pkg::ST_FLUSH: begin
        // Skip clean or invalid entries; read the tag of a dirty one.
        ram_req.raddr = idx_lo;
        if (idx_q != CntW'(N) && !vd[idx_lo]) begin
          idx_d = idx_q + 1'b1;
        end
      end

      sccr_pkg::ST_FLUSH_OUT: begin
        ram_req.raddr = idx_lo;
        if (out_free) begin
          valid_d[idx_lo] = 1'b0;
          dirty_d[idx_lo] = 1'b0;
          idx_d           = idx_q + 1'b1;
          out_valid_d     = 1'b1;
          out_last_d      = flush_last;
          out_data_d      = {7'd0, miss_cnt_q, hit_cnt_q, 1'b0, ram_rdata, 1'b1,
                             sccr_pkg::SlotW'(idx_lo), 1'b0};
        end
      end

      sccr_pkg::ST_CLEAR: begin
        if (out_free) begin
          hit_cnt_d   = '0;
          miss_cnt_d  = '0;
          out_valid_d = 1'b1;
          out_last_d  = 1'b1;
          out_data_d  = '0;
        end
      end

      default: begin
        cmp_vld_d = 1'b0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sccr_pkg::ST_IDLE;
      idx_q       <= '0;
      cmp_vld_q   <= 1'b0;
      hand_q      <= '0;
      valid_q     <= '0;
      dirty_q     <= '0;
      ref_q       <= '0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cmp_vld_q   <= cmp_vld_d;
      hand_q      <= hand_d;
      valid_q     <= valid_d;
      dirty_q     <= dirty_d;
      ref_q       <= ref_d;
      hit_cnt_q   <= hit_cnt_d;
      miss_cnt_q  <= miss_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    sector_q   <= sector_d;
    cmp_idx_q  <= cmp_idx_d;
    slot_q     <= slot_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

[sim/sccr_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sccr_checker
// Watches both stream channels of the sector cache core, keeps its own copy
// of the tag, valid, dirty and referenced state, and checks every result.
// ----------------------------------------------------------------------------
module sccr_checker
  import sccr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  input  logic [TagW-1:0]     s_tdata_i,   // [31:0] sector
  input  logic [OpW-1:0]      s_tuser_i,   // [1:0] operation
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  input  logic [OutDataW-1:0] m_tdata_i,
  input  logic                m_tlast_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o,
  output int unsigned         checked_o,
  output int unsigned         hits_o,
  output int unsigned         writebacks_o
);

  typedef struct packed {
    logic              hit;
    logic [SlotW-1:0]  slot;
    logic              wb_needed;
    logic [TagW-1:0]   wb_sector;
    logic              fill_needed;
    logic [TotalW-1:0] hit_total;
    logic [TotalW-1:0] miss_total;
    logic              last;
  } sector_result_t;

  sector_result_t    expected_results[$];

  logic              line_valid [CacheEntries];
  logic              line_dirty [CacheEntries];
  logic              line_ref   [CacheEntries];
  logic [TagW-1:0]   line_tag   [CacheEntries];
  logic [IdxW-1:0]   hand;
  logic [TotalW-1:0] hit_count;
  logic [TotalW-1:0] miss_count;

  int unsigned fail_count = 0;
  int unsigned pending    = 0;
  int unsigned checked    = 0;
  int unsigned hits_seen  = 0;
  int unsigned wb_seen    = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;
  assign checked_o    = checked;
  assign hits_o       = hits_seen;
  assign writebacks_o = wb_seen;

  function automatic logic [TotalW-1:0] sat_inc(input logic [TotalW-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [TagW-1:0] got,
                                 input logic [TagW-1:0] want);
    $display("ERROR %0t ns: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    fail_count++;
  endtask

  task automatic check_field(input string what, input logic [TagW-1:0] got,
                             input logic [TagW-1:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic push_result(input logic hit, input int unsigned slot,
                             input logic wb, input logic [TagW-1:0] wb_sector,
                             input logic fill, input logic last);
    sector_result_t r;
    r.hit         = hit;
    r.slot        = slot[SlotW-1:0];
    r.wb_needed   = wb;
    r.wb_sector   = wb_sector;
    r.fill_needed = fill;
    r.hit_total   = hit_count;
    r.miss_total  = miss_count;
    r.last        = last;
    expected_results.push_back(r);
  endtask

  // Lowest matching valid entry wins; a miss runs the second-chance sweep.
  task automatic model_access(input op_e op, input logic [TagW-1:0] sector);
    int unsigned     idx;
    logic            found;
    logic            done;
    logic            wb;
    logic [TagW-1:0] wb_sector;
    logic [IdxW-1:0] victim;
    found = 1'b0;
    idx   = 0;
    for (int i = CacheEntries - 1; i >= 0; i--) begin
      if (line_valid[i] && line_tag[i] == sector) begin
        found = 1'b1;
        idx   = i;
      end
    end
    if (found) begin
      hit_count     = sat_inc(hit_count);
      line_ref[idx] = 1'b1;
      if (op == OP_WRITE) line_dirty[idx] = 1'b1;
      push_result(1'b1, idx, 1'b0, '0, 1'b0, 1'b1);
    end else begin
      miss_count = sat_inc(miss_count);
      victim     = hand;
      done       = 1'b0;
      for (int n = 0; n < 2 * CacheEntries + 1 && !done; n++) begin
        if (!line_valid[victim] || !line_ref[victim]) begin
          done = 1'b1;
        end else begin
          line_ref[victim] = 1'b0;
          victim = (victim == CacheEntries - 1) ? '0 : victim + 1'b1;
        end
      end
      hand      = victim;
      wb        = line_valid[victim] && line_dirty[victim];
      wb_sector = wb ? line_tag[victim] : '0;
      line_valid[victim] = 1'b1;
      line_dirty[victim] = (op == OP_WRITE);
      line_tag[victim]   = sector;
      line_ref[victim]   = 1'b1;
      push_result(1'b0, victim, wb, wb_sector, 1'b1, 1'b1);
    end
  endtask

  // Write back every valid dirty entry in index order and drop it.
  task automatic model_flush();
    int last_idx;
    last_idx = -1;
    for (int i = 0; i < CacheEntries; i++)
      if (line_valid[i] && line_dirty[i]) last_idx = i;
    for (int i = 0; i < CacheEntries; i++) begin
      if (line_valid[i] && line_dirty[i]) begin
        push_result(1'b0, i, 1'b1, line_tag[i], 1'b0, i == last_idx);
        line_valid[i] = 1'b0;
        line_dirty[i] = 1'b0;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sector_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < CacheEntries; i++) begin
        line_valid[i] = 1'b0;
        line_dirty[i] = 1'b0;
        line_ref[i]   = 1'b0;
        line_tag[i]   = '0;
      end
      hand       = '0;
      hit_count  = '0;
      miss_count = '0;
      expected_results.delete();
      pending = 0;
    end else begin
      // Check the result first: it always belongs to an earlier request.
      if (m_tvalid_i && m_tready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing pending, tdata[31:0]",
                          m_tdata_i[31:0], '0);
        end else begin
          want = expected_results.pop_front();
          check_field("hit", m_tdata_i[0], want.hit);
          check_field("slot", m_tdata_i[6:1], want.slot);
          check_field("writeback_needed", m_tdata_i[7], want.wb_needed);
          check_field("writeback_sector", m_tdata_i[39:8], want.wb_sector);
          check_field("fill_needed", m_tdata_i[40], want.fill_needed);
          check_field("hit_total", m_tdata_i[72:41], want.hit_total);
          check_field("miss_total", m_tdata_i[104:73], want.miss_total);
          check_field("last", m_tlast_i, want.last);
          checked++;
          if (want.hit) hits_seen++;
          if (want.wb_needed) wb_seen++;
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        case (op_e'(s_tuser_i))
          OP_READ, OP_WRITE: model_access(op_e'(s_tuser_i), s_tdata_i);
          OP_FLUSH:          model_flush();
          default: begin
            hit_count  = '0;
            miss_count = '0;
            push_result(1'b0, 0, 1'b0, '0, 1'b0, 1'b1);
          end
        endcase
      end
      pending = expected_results.size();
    end
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives reads, writes, flushes and counter clears into the sector cache core
// and gives the verdict; the checker beside the core predicts every result.
// ----------------------------------------------------------------------------
module testbench;
  import sccr_pkg::*;

  localparam int unsigned RandomItems = 113;
  localparam int unsigned HotSectors  = 16;
  // Worst single request: full tag scan plus a full sweep, with margin.
  localparam int unsigned SettleCycles = 4 * CacheEntries + 200;
  localparam int unsigned DrainLimit   = 50000;

  logic                clk_i   = 1'b0;
  logic                rst_ni  = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [TagW-1:0]     s_tdata  = '0;   // [31:0] sector
  op_e                 s_tuser  = OP_READ;  // [1:0] operation
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tlast;

  // High while both sides run without idling.
  logic                steady = 1'b0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned hits;
  int unsigned writebacks;

  int unsigned n_reads   = 0;
  int unsigned n_writes  = 0;
  int unsigned n_flushes = 0;
  int unsigned n_clears  = 0;

  logic [TagW-1:0] hot_sectors [HotSectors];

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  sector_cache_clock_replacement_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  sccr_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tlast_i    (m_tlast),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .hits_o       (hits),
    .writebacks_o (writebacks)
  );

  // Stall the result side about 8 percent of the time, never in the steady stretch.
  always @(negedge clk_i) begin
    m_tready <= steady || ($urandom_range(99) >= 8);
  end

  // Hand one request to the core. Enter and leave at a falling edge; tvalid
  // stays high into the next call so back-to-back transactions need no gap.
  task automatic issue_request(input op_e op, input logic [TagW-1:0] sector);
    while (!steady && $urandom_range(99) < 8) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= sector;
    s_tuser  <= op;
    case (op)
      OP_READ:  n_reads++;
      OP_WRITE: n_writes++;
      OP_FLUSH: n_flushes++;
      default:  n_clears++;
    endcase
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    int unsigned     pick;
    int unsigned     waited;
    logic [TagW-1:0] sector;
    op_e             op;

    for (int i = 0; i < HotSectors; i++) hot_sectors[i] = $urandom();
    hot_sectors[0] = '0;
    hot_sectors[1] = '1;

    // Hold reset, then release it once.
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: extreme sectors, hits on clean and dirty lines, a flush with
    // results and one with none, refill after flush, and counter clears.
    issue_request(OP_READ,  32'h0000_0000);
    issue_request(OP_READ,  32'h0000_0000);
    issue_request(OP_WRITE, 32'hFFFF_FFFF);
    issue_request(OP_WRITE, 32'hFFFF_FFFF);
    issue_request(OP_READ,  32'h0000_0000);
    issue_request(OP_WRITE, 32'h5555_5555);
    issue_request(OP_READ,  32'hAAAA_AAAA);
    issue_request(OP_WRITE, 32'hAAAA_AAAA);
    issue_request(OP_FLUSH, $urandom());
    issue_request(OP_FLUSH, 32'hFFFF_FFFF);
    issue_request(OP_READ,  32'hFFFF_FFFF);
    issue_request(OP_CLEAR, 32'h0000_0000);
    issue_request(OP_READ,  32'h0000_0000);
    issue_request(OP_WRITE, 32'h5555_5555);
    issue_request(OP_CLEAR, 32'hFFFF_FFFF);
    issue_request(OP_WRITE, 32'h0000_0001);
    issue_request(OP_READ,  32'h8000_0000);

    // Random: a small hot set for hits mixed with fresh sectors that fill the
    // cache and force evictions, plus occasional flushes and clears.
    for (int k = 0; k < RandomItems; k++) begin
      if (k == 60) begin
        // Drain the core completely before going on.
        s_tvalid <= 1'b0;
        @(negedge clk_i);
        while (pending != 0) @(negedge clk_i);
      end
      steady <= (k >= 70 && k < 110);
      pick = $urandom_range(99);
      if (pick < 5) begin
        issue_request(OP_FLUSH, $urandom());
      end else if (pick < 8) begin
        issue_request(OP_CLEAR, $urandom());
      end else begin
        op     = ($urandom_range(1) == 0) ? OP_READ : OP_WRITE;
        sector = ($urandom_range(99) < 45) ? hot_sectors[$urandom_range(HotSectors - 1)]
                                           : $urandom();
        issue_request(op, sector);
      end
    end
    s_tvalid <= 1'b0;
    steady   <= 1'b0;

    // Wait for every expected result, then let a late extra one show up.
    waited = 0;
    while (pending != 0 && waited < DrainLimit) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (SettleCycles) @(negedge clk_i);

    if (pending != 0) $display("ERROR: %0d expected results never arrived", pending);
    $display("Covered %0d reads, %0d writes, %0d flushes and %0d counter clears.",
             n_reads, n_writes, n_flushes, n_clears);
    $display("Checked %0d results: %0d hits, %0d writebacks, %0d mismatches.",
             checked, hits, writebacks, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard stop far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("ERROR: simulation timed out");
    $display("Verification failed");
    $finish;
  end

endmodule
